FILE: hw/rtl/cpe_pkg.sv
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared types, sizes and codes of the cartesian product entry decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cpe_pkg;

  // Table geometry; the load address fields cover exactly these ranges.
  localparam int MAX_DISTS  = 8;
  localparam int MAX_SETS   = 16;
  localparam int MAX_PARAMS = 8;
  localparam int HANDLE_W   = 16;

  localparam int DIST_W = $clog2(MAX_DISTS);           // distribution index
  localparam int SET_W  = $clog2(MAX_SETS);            // value set index
  localparam int SLOT_W = $clog2(MAX_PARAMS);          // entry slot index
  localparam int DTOT_W = $clog2(MAX_DISTS + 1);       // distribution count
  localparam int SCNT_W = $clog2(MAX_SETS + 1);        // sets per distribution
  localparam int ECNT_W = $clog2(MAX_PARAMS + 1);      // entries per set
  localparam int SIDX_W = DIST_W + SET_W;              // set table address
  localparam int EIDX_W = SIDX_W + SLOT_W;             // entry store address
  localparam int NSETS  = MAX_DISTS * MAX_SETS;
  localparam int NENT   = NSETS * MAX_PARAMS;

  localparam int IDX_W  = 32;                          // permutation number
  localparam int PERM_W = 33;                          // permutation total
  localparam int NPAR_W = 7;                           // parameter total
  localparam int PIDX_W = 8;                           // parameter index
  localparam int PROD_W = PERM_W + SCNT_W;

  localparam logic [PERM_W-1:0] PERM_MAX = {PERM_W{1'b1}};

  // Divider retires DIV_BITS quotient bits per cycle.
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = IDX_W / DIV_BITS;
  localparam int DSTEP_W   = $clog2(DIV_STEPS);

  // Configuration register word index (paddr[2]).
  localparam logic CFG_IDX_PERM  = 1'b0;
  localparam logic CFG_IDX_VALID = 1'b1;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_INDEX    = 2'd1,
    ST_PARAM_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LD_WR,
    S_PINIT,
    S_PERM,
    S_CHECK,
    S_DIV,
    S_DIG_RD,
    S_DIG_ACC,
    S_PCHK,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic cap;        // latch the request fields
    logic load;       // load: write store, grow counts, read set count
    logic load_wr;    // load: write back grown set entry count
    logic clear;      // drop all counts
    logic perm_init;  // start permutation product
    logic perm_step;  // multiply in one distribution
    logic check;      // latch index check, set up digit walk
    logic div_step;   // one divider step
    logic dig_rd;     // read entry count of the picked set
    logic dig_acc;    // add entry count, move to next distribution
    logic pchk;       // parameter index check, set up scan
    logic scan;       // scan one distribution for the target entry
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic dist_empty;
    logic perm_last;
    logic idx_ok;
    logic div_last;
    logic dig_last;
    logic param_ok;
    logic hit;
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cpe_ctrl.sv
// ----------------------------------------------------------------------------
// cpe_ctrl
// Sequencer: steps the datapath through load, product, digit and scan passes.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire cpe_pkg::stat_t stat,
  output cpe_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                out_valid
);

  cpe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpe_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpe_pkg::S_IDLE: begin
        if (start) state_nxt = cpe_pkg::S_DISPATCH;
      end
      cpe_pkg::S_DISPATCH: begin
        if (stat.req == cpe_pkg::REQ_LOAD) state_nxt = cpe_pkg::S_LD_WR;
        else                               state_nxt = cpe_pkg::S_PINIT;
      end
      cpe_pkg::S_LD_WR: state_nxt = cpe_pkg::S_PINIT;
      cpe_pkg::S_PINIT: begin
        if (stat.dist_empty) state_nxt = cpe_pkg::S_CHECK;
        else                 state_nxt = cpe_pkg::S_PERM;
      end
      cpe_pkg::S_PERM: begin
        if (stat.perm_last) state_nxt = cpe_pkg::S_CHECK;
      end
      cpe_pkg::S_CHECK: begin
        if (stat.idx_ok) state_nxt = cpe_pkg::S_DIV;
        else             state_nxt = cpe_pkg::S_DONE;
      end
      cpe_pkg::S_DIV: begin
        if (stat.div_last) state_nxt = cpe_pkg::S_DIG_RD;
      end
      cpe_pkg::S_DIG_RD: state_nxt = cpe_pkg::S_DIG_ACC;
      cpe_pkg::S_DIG_ACC: begin
        if (stat.dig_last) state_nxt = cpe_pkg::S_PCHK;
        else               state_nxt = cpe_pkg::S_DIV;
      end
      cpe_pkg::S_PCHK: begin
        if (stat.req == cpe_pkg::REQ_QUERY && stat.param_ok) state_nxt = cpe_pkg::S_SCAN;
        else                                                 state_nxt = cpe_pkg::S_DONE;
      end
      cpe_pkg::S_SCAN: begin
        if (stat.hit) state_nxt = cpe_pkg::S_DONE;
      end
      cpe_pkg::S_DONE: state_nxt = cpe_pkg::S_IDLE;
      default:         state_nxt = cpe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      cpe_pkg::S_IDLE: begin
        busy    = 1'b0;
        cmd.cap = start;
      end
      cpe_pkg::S_DISPATCH: begin
        cmd.load  = (stat.req == cpe_pkg::REQ_LOAD);
        cmd.clear = (stat.req == cpe_pkg::REQ_CLEAR);
      end
      cpe_pkg::S_LD_WR:   cmd.load_wr   = 1'b1;
      cpe_pkg::S_PINIT:   cmd.perm_init = 1'b1;
      cpe_pkg::S_PERM:    cmd.perm_step = 1'b1;
      cpe_pkg::S_CHECK:   cmd.check     = 1'b1;
      cpe_pkg::S_DIV:     cmd.div_step  = 1'b1;
      cpe_pkg::S_DIG_RD:  cmd.dig_rd    = 1'b1;
      cpe_pkg::S_DIG_ACC: cmd.dig_acc   = 1'b1;
      cpe_pkg::S_PCHK:    cmd.pchk      = 1'b1;
      cpe_pkg::S_SCAN:    cmd.scan      = 1'b1;
      cpe_pkg::S_DONE:    out_valid     = 1'b1;
      default:            busy          = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cpe_dp.sv
// ----------------------------------------------------------------------------
// cpe_dp
// Datapath: entry store, set count table, product, radix divider and scan.
// ----------------------------------------------------------------------------
`default_nettype none

module cpe_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire cpe_pkg::cmd_t                   cmd,
  output cpe_pkg::stat_t                       stat,
  input  wire logic [1:0]                      in_req_type,
  input  wire logic [cpe_pkg::DIST_W-1:0]      in_dist_sel,
  input  wire logic [cpe_pkg::SET_W-1:0]       in_set_sel,
  input  wire logic [cpe_pkg::SLOT_W-1:0]      in_slot_sel,
  input  wire logic [cpe_pkg::HANDLE_W-1:0]    in_name_handle,
  input  wire logic [cpe_pkg::HANDLE_W-1:0]    in_value_handle,
  input  wire logic [cpe_pkg::PIDX_W-1:0]      in_param_index,
  input  wire logic [cpe_pkg::IDX_W-1:0]       perm_index,
  input  wire logic                            index_valid,
  output logic [1:0]                           out_status,
  output logic [cpe_pkg::PERM_W-1:0]           out_num_permutations,
  output logic [cpe_pkg::NPAR_W-1:0]           out_param_total,
  output logic [cpe_pkg::HANDLE_W-1:0]         out_entry_name,
  output logic [cpe_pkg::HANDLE_W-1:0]         out_entry_value
);

  // Latched request
  cpe_pkg::req_t                  req_r;
  logic [cpe_pkg::DIST_W-1:0]     dist_r;
  logic [cpe_pkg::SET_W-1:0]      set_r;
  logic [cpe_pkg::SLOT_W-1:0]     slot_r;
  logic [cpe_pkg::HANDLE_W-1:0]   name_r;
  logic [cpe_pkg::HANDLE_W-1:0]   value_r;
  logic [cpe_pkg::PIDX_W-1:0]     pidx_r;

  // Table counts
  logic [cpe_pkg::SCNT_W-1:0]     dset_cnt_r [cpe_pkg::MAX_DISTS];
  logic [cpe_pkg::DTOT_W-1:0]     dist_total_r;

  // Set entry counts: memory plus per-entry valid bits (unwritten reads zero)
  logic [cpe_pkg::ECNT_W-1:0]     cnt_mem [cpe_pkg::NSETS];
  logic [cpe_pkg::NSETS-1:0]      cnt_vld_r;
  logic [cpe_pkg::ECNT_W-1:0]     cnt_rd_r;
  logic                           cnt_rdv_r;
  logic [cpe_pkg::SIDX_W-1:0]     cnt_addr;
  logic [cpe_pkg::ECNT_W-1:0]     cnt_eff;
  logic [cpe_pkg::ECNT_W-1:0]     cnt_new;
  logic [cpe_pkg::ECNT_W-1:0]     slot_cnt;

  // Entry store: name in the upper half, value in the lower half
  logic [2*cpe_pkg::HANDLE_W-1:0] ent_mem [cpe_pkg::NENT];
  logic [2*cpe_pkg::HANDLE_W-1:0] ent_rd_r;

  // Walk state
  logic [cpe_pkg::DIST_W-1:0]     d_r;
  logic [cpe_pkg::DSTEP_W-1:0]    s_r;
  logic [cpe_pkg::IDX_W-1:0]      n_r;
  logic [cpe_pkg::SET_W-1:0]      rem_r;
  logic [cpe_pkg::SET_W-1:0]      digit_r [cpe_pkg::MAX_DISTS];
  logic [cpe_pkg::ECNT_W-1:0]     ecnt_r  [cpe_pkg::MAX_DISTS];
  logic [cpe_pkg::PERM_W-1:0]     perms_r;
  logic [cpe_pkg::NPAR_W-1:0]     nparams_r;
  logic [cpe_pkg::NPAR_W-1:0]     target_r;
  logic [cpe_pkg::NPAR_W-1:0]     acc_r;
  cpe_pkg::status_t               status_r;
  logic                           found_r;

  logic [cpe_pkg::DIST_W-1:0]     dsel;
  logic [cpe_pkg::SCNT_W-1:0]     dcnt;
  logic [cpe_pkg::PROD_W-1:0]     prod;
  logic [cpe_pkg::PERM_W-1:0]     prod_sat;
  logic [cpe_pkg::SET_W-1:0]      dv_rem;
  logic [cpe_pkg::SCNT_W-1:0]     dv_t;
  logic [cpe_pkg::DIV_BITS-1:0]   dv_q;
  logic [cpe_pkg::NPAR_W-1:0]     acc_sum;
  logic [cpe_pkg::NPAR_W-1:0]     slot_off;
  logic                           idx_ok;

  // Single read port on the distribution set counts
  assign dsel = cmd.load ? dist_r : d_r;
  assign dcnt = dset_cnt_r[dsel];

  assign cnt_eff  = cnt_rdv_r ? cnt_rd_r : '0;
  assign slot_cnt = cpe_pkg::ECNT_W'(slot_r) + 1'b1;
  assign cnt_new  = (cnt_eff < slot_cnt) ? slot_cnt : cnt_eff;
  assign cnt_addr = cmd.load ? {dist_r, set_r} : {d_r, rem_r};

  // Saturating product step
  assign prod     = cpe_pkg::PROD_W'(perms_r) * cpe_pkg::PROD_W'(dcnt);
  assign prod_sat = (prod > cpe_pkg::PROD_W'(cpe_pkg::PERM_MAX)) ?
                    cpe_pkg::PERM_MAX : prod[cpe_pkg::PERM_W-1:0];

  assign idx_ok = index_valid && (cpe_pkg::PERM_W'(perm_index) < perms_r);

  // Restoring divide by the set count, DIV_BITS bits per cycle
  always_comb begin
    dv_rem = rem_r;
    dv_t   = '0;
    dv_q   = '0;
    for (int i = 0; i < cpe_pkg::DIV_BITS; i++) begin
      dv_t = {dv_rem, n_r[cpe_pkg::IDX_W-1-i]};
      if (dv_t >= dcnt) begin
        dv_rem                      = cpe_pkg::SET_W'(dv_t - dcnt);
        dv_q[cpe_pkg::DIV_BITS-1-i] = 1'b1;
      end else begin
        dv_rem = cpe_pkg::SET_W'(dv_t);
      end
    end
  end

  // Mirrored-order scan
  assign acc_sum  = acc_r + cpe_pkg::NPAR_W'(ecnt_r[d_r]);
  assign slot_off = acc_sum - target_r - 1'b1;

  always_comb begin
    stat.req        = req_r;
    stat.dist_empty = (dist_total_r == '0);
    stat.perm_last  = (cpe_pkg::DTOT_W'(d_r) == dist_total_r - 1'b1);
    stat.idx_ok     = idx_ok;
    stat.div_last   = (s_r == cpe_pkg::DSTEP_W'(cpe_pkg::DIV_STEPS - 1));
    stat.dig_last   = (d_r == '0);
    stat.param_ok   = (cpe_pkg::PIDX_W'(nparams_r) > pidx_r);
    stat.hit        = (target_r < acc_sum);
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r   <= cpe_pkg::req_t'(in_req_type);
      dist_r  <= in_dist_sel;
      set_r   <= in_set_sel;
      slot_r  <= in_slot_sel;
      name_r  <= in_name_handle;
      value_r <= in_value_handle;
      pidx_r  <= in_param_index;
    end
  end

  // Counts and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < cpe_pkg::MAX_DISTS; i++) dset_cnt_r[i] <= '0;
      dist_total_r <= '0;
      cnt_vld_r    <= '0;
    end else begin
      if (cmd.load) begin
        if (dcnt < cpe_pkg::SCNT_W'(set_r) + 1'b1)
          dset_cnt_r[dist_r] <= cpe_pkg::SCNT_W'(set_r) + 1'b1;
        if (dist_total_r < cpe_pkg::DTOT_W'(dist_r) + 1'b1)
          dist_total_r <= cpe_pkg::DTOT_W'(dist_r) + 1'b1;
      end
      if (cmd.load_wr) cnt_vld_r[{dist_r, set_r}] <= 1'b1;
    end
  end

  // Set entry count memory
  always_ff @(posedge clk) begin
    if (cmd.load_wr) cnt_mem[{dist_r, set_r}] <= cnt_new;
    if (cmd.load || cmd.dig_rd) begin
      cnt_rd_r  <= cnt_mem[cnt_addr];
      cnt_rdv_r <= cnt_vld_r[cnt_addr];
    end
  end

  // Entry store
  always_ff @(posedge clk) begin
    if (cmd.load) ent_mem[{dist_r, set_r, slot_r}] <= {name_r, value_r};
    if (cmd.scan && stat.hit)
      ent_rd_r <= ent_mem[{d_r, digit_r[d_r], slot_off[cpe_pkg::SLOT_W-1:0]}];
  end

  // Walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
      s_r <= '0;
    end else begin
      if (cmd.perm_init) d_r <= '0;
      if (cmd.perm_step) d_r <= d_r + 1'b1;
      if (cmd.check || cmd.pchk) d_r <= cpe_pkg::DIST_W'(dist_total_r - 1'b1);
      if (cmd.dig_acc && !stat.dig_last) d_r <= d_r - 1'b1;
      if (cmd.scan && !stat.hit) d_r <= d_r - 1'b1;
      if (cmd.check || cmd.dig_acc) s_r <= '0;
      if (cmd.div_step) s_r <= s_r + 1'b1;
    end
  end

  // Product, digits, totals and result fields
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      status_r <= cpe_pkg::ST_OK;
      found_r  <= 1'b0;
    end
    if (cmd.perm_init) perms_r <= stat.dist_empty ? '0 : cpe_pkg::PERM_W'(1);
    if (cmd.perm_step) perms_r <= prod_sat;
    if (cmd.check) begin
      nparams_r <= '0;
      n_r       <= perm_index;
      rem_r     <= '0;
      if (req_r == cpe_pkg::REQ_QUERY && !idx_ok) status_r <= cpe_pkg::ST_NO_INDEX;
    end
    if (cmd.div_step) begin
      n_r   <= {n_r[cpe_pkg::IDX_W-cpe_pkg::DIV_BITS-1:0], dv_q};
      rem_r <= dv_rem;
    end
    if (cmd.dig_rd) digit_r[d_r] <= rem_r;
    if (cmd.dig_acc) begin
      ecnt_r[d_r] <= cnt_eff;
      nparams_r   <= nparams_r + cpe_pkg::NPAR_W'(cnt_eff);
      rem_r       <= '0;
    end
    if (cmd.pchk) begin
      acc_r    <= '0;
      target_r <= nparams_r - cpe_pkg::NPAR_W'(pidx_r) - 1'b1;
      if (req_r == cpe_pkg::REQ_QUERY && !stat.param_ok) status_r <= cpe_pkg::ST_PARAM_RANGE;
    end
    if (cmd.scan) begin
      if (stat.hit) found_r <= 1'b1;
      else          acc_r   <= acc_sum;
    end
  end

  assign out_status           = status_r;
  assign out_num_permutations = perms_r;
  assign out_param_total      = nparams_r;
  assign out_entry_name       = found_r ? ent_rd_r[2*cpe_pkg::HANDLE_W-1:cpe_pkg::HANDLE_W] : '0;
  assign out_entry_value      = found_r ? ent_rd_r[cpe_pkg::HANDLE_W-1:0] : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/cartesian_product_entry_decoder.sv
// ----------------------------------------------------------------------------
// cartesian_product_entry_decoder
// Passes: every item forms the product; a load first adds a write-back
//   step; items with a valid index also walk the digits, and a query
//   that passes both index checks then scans. After the result strobe the
//   block returns to idle, where the next start is taken.
// Throughput: one item at a time, set by the 8-bit-per-cycle radix divider
//   and the single read port of the set count memory. No stall input.
// Reset: rst_n synchronous, active low; clears the table counts and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_product_entry_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_req_type,
  input  wire logic [cpe_pkg::DIST_W-1:0]   in_dist_sel,
  input  wire logic [cpe_pkg::SET_W-1:0]    in_set_sel,
  input  wire logic [cpe_pkg::SLOT_W-1:0]   in_slot_sel,
  input  wire logic [cpe_pkg::HANDLE_W-1:0] in_name_handle,
  input  wire logic [cpe_pkg::HANDLE_W-1:0] in_value_handle,
  input  wire logic [cpe_pkg::PIDX_W-1:0]   in_param_index,
  // result channel
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [cpe_pkg::PERM_W-1:0]        out_num_permutations,
  output logic [cpe_pkg::NPAR_W-1:0]        out_param_total,
  output logic [cpe_pkg::HANDLE_W-1:0]      out_entry_name,
  output logic [cpe_pkg::HANDLE_W-1:0]      out_entry_value,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Configuration registers. Word select is paddr[2]; byte offset bits are
  // ignored, so every transfer lands on one of the two registers.
  logic [cpe_pkg::IDX_W-1:0] perm_index_r;
  logic                      index_valid_r;
  logic                      cfg_wr;

  cpe_pkg::cmd_t  cmd;
  cpe_pkg::stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_index_r  <= '0;
      index_valid_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        cpe_pkg::CFG_IDX_PERM:  perm_index_r  <= pwdata;
        cpe_pkg::CFG_IDX_VALID: index_valid_r <= pwdata[0];
        default:                perm_index_r  <= perm_index_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cpe_pkg::CFG_IDX_PERM:  prdata = perm_index_r;
      cpe_pkg::CFG_IDX_VALID: prdata = {31'b0, index_valid_r};
      default:                prdata = '0;
    endcase
  end

  // Sequencer: one state per pass step; DONE drives the result strobe.
  cpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Datapath: a load grows the counts; every item recomputes the saturating
  // product and, with a valid index, the mixed-radix digits from the last
  // distribution down and the parameter total; in-range queries scan too.
  cpe_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_req_type          (in_req_type),
    .in_dist_sel          (in_dist_sel),
    .in_set_sel           (in_set_sel),
    .in_slot_sel          (in_slot_sel),
    .in_name_handle       (in_name_handle),
    .in_value_handle      (in_value_handle),
    .in_param_index       (in_param_index),
    .perm_index           (perm_index_r),
    .index_valid          (index_valid_r),
    .out_status           (out_status),
    .out_num_permutations (out_num_permutations),
    .out_param_total      (out_param_total),
    .out_entry_name       (out_entry_name),
    .out_entry_value      (out_entry_value)
  );

endmodule

`default_nettype wire

FILE: tb/tb_cartesian_product_entry_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartesian_product_entry_decoder
// Self-checking bench for the mixed-radix entry decoder. Commands are sent with
// random gaps; a cycle-free model of the table predicts every result, and the
// result strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_cartesian_product_entry_decoder;

  localparam int STALL_LIMIT = 2000;   // cycles with no transfer anywhere
  localparam int RANDOM_CMDS = 1100;
  localparam int DRAIN_WAIT  = 100;    // longer than the worst query latency

  // One command as it goes out on the input channel.
  typedef struct packed {
    cpe_pkg::req_t                req;
    logic [cpe_pkg::DIST_W-1:0]   dsel;
    logic [cpe_pkg::SET_W-1:0]    ssel;
    logic [cpe_pkg::SLOT_W-1:0]   slot;
    logic [cpe_pkg::HANDLE_W-1:0] name;
    logic [cpe_pkg::HANDLE_W-1:0] value;
    logic [cpe_pkg::PIDX_W-1:0]   pidx;
  } cmd_item_t;

  // One result as it comes back on the result channel.
  typedef struct packed {
    cpe_pkg::status_t             status;
    logic [cpe_pkg::PERM_W-1:0]   perms;
    logic [cpe_pkg::NPAR_W-1:0]   npar;
    logic [cpe_pkg::HANDLE_W-1:0] name;
    logic [cpe_pkg::HANDLE_W-1:0] value;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // command channel
  logic      start = 1'b0;
  wire logic busy;
  cmd_item_t cur = '0;

  // result channel
  wire logic                         out_valid;
  wire logic [1:0]                   out_status;
  wire logic [cpe_pkg::PERM_W-1:0]   out_num_permutations;
  wire logic [cpe_pkg::NPAR_W-1:0]   out_param_total;
  wire logic [cpe_pkg::HANDLE_W-1:0] out_entry_name;
  wire logic [cpe_pkg::HANDLE_W-1:0] out_entry_value;

  // configuration port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire logic [31:0] prdata;
  wire logic        pready;

  cartesian_product_entry_decoder u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (cur.req),
    .in_dist_sel          (cur.dsel),
    .in_set_sel           (cur.ssel),
    .in_slot_sel          (cur.slot),
    .in_name_handle       (cur.name),
    .in_value_handle      (cur.value),
    .in_param_index       (cur.pidx),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_num_permutations (out_num_permutations),
    .out_param_total      (out_param_total),
    .out_entry_name       (out_entry_name),
    .out_entry_value      (out_entry_value),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Table model. Updated once per accepted command, in acceptance order.
  // --------------------------------------------------------------------------
  logic [cpe_pkg::HANDLE_W-1:0] tbl_name  [cpe_pkg::NENT];
  logic [cpe_pkg::HANDLE_W-1:0] tbl_value [cpe_pkg::NENT];
  int unsigned                  set_len   [cpe_pkg::NSETS];     // entries per value set
  int unsigned                  dist_sets [cpe_pkg::MAX_DISTS]; // value sets per dist
  int unsigned                  n_dists;
  logic [31:0]                  cfg_perm  = '0;
  logic                         cfg_valid = 1'b0;

  function automatic void wipe_table();
    for (int i = 0; i < cpe_pkg::NENT; i++) begin
      tbl_name[i]  = '0;
      tbl_value[i] = '0;
    end
    for (int i = 0; i < cpe_pkg::NSETS; i++) set_len[i] = 0;
    for (int i = 0; i < cpe_pkg::MAX_DISTS; i++) dist_sets[i] = 0;
    n_dists = 0;
  endfunction

  // Product of set counts, saturating at 33 bits; any empty distribution -> 0.
  function automatic logic [cpe_pkg::PERM_W-1:0] perm_total();
    logic [63:0] n;
    n = 1;
    if (n_dists == 0) return '0;
    for (int d = 0; d < n_dists; d++) begin
      if (dist_sets[d] == 0) return '0;
      if (n > 64'(cpe_pkg::PERM_MAX) / dist_sets[d]) n = 64'(cpe_pkg::PERM_MAX);
      else n = n * dist_sets[d];
    end
    return n[cpe_pkg::PERM_W-1:0];
  endfunction

  // Entries in the sets the permutation number picks; last distribution is
  // the least significant digit.
  function automatic int unsigned params_picked();
    logic [31:0] n;
    int unsigned tot;
    int unsigned c;
    n = cfg_perm;
    tot = 0;
    for (int d = n_dists; d > 0; d--) begin
      c = dist_sets[d-1];
      tot += set_len[(d-1)*cpe_pkg::MAX_SETS + n % c];
      n = n / c;
    end
    return tot;
  endfunction

  function automatic logic index_in_range();
    return cfg_valid && ({1'b0, cfg_perm} < perm_total());
  endfunction

  function automatic answer_t resolve_cmd(cmd_item_t c);
    answer_t     a;
    int unsigned np;
    int unsigned target;
    int unsigned acc;
    int unsigned cnt;
    int unsigned si;
    int unsigned ei;
    logic [31:0] n;
    logic        ok;
    a = '0;
    np = 0;
    case (c.req)
      cpe_pkg::REQ_LOAD: begin
        si = c.dsel * cpe_pkg::MAX_SETS + c.ssel;
        ei = si * cpe_pkg::MAX_PARAMS + c.slot;
        tbl_name[ei]  = c.name;
        tbl_value[ei] = c.value;
        if (set_len[si] < c.slot + 1) set_len[si] = c.slot + 1;
        if (dist_sets[c.dsel] < c.ssel + 1) dist_sets[c.dsel] = c.ssel + 1;
        if (n_dists < c.dsel + 1) n_dists = c.dsel + 1;
      end
      cpe_pkg::REQ_CLEAR: wipe_table();
      default: begin
      end
    endcase

    a.perms = perm_total();
    ok = index_in_range();
    if (ok) np = params_picked();
    a.npar   = np[cpe_pkg::NPAR_W-1:0];
    a.status = cpe_pkg::ST_OK;

    if (c.req == cpe_pkg::REQ_QUERY) begin
      if (!ok) begin
        a.status = cpe_pkg::ST_NO_INDEX;
      end else if (c.pidx >= np) begin
        a.status = cpe_pkg::ST_PARAM_RANGE;
      end else begin
        // parameters are counted mirrored: index 0 is the last one found
        target = np - c.pidx - 1;
        acc = 0;
        n = cfg_perm;
        for (int d = n_dists; d > 0; d--) begin
          cnt = dist_sets[d-1];
          si = (d-1)*cpe_pkg::MAX_SETS + n % cnt;
          acc += set_len[si];
          if (target < acc) begin
            ei = si * cpe_pkg::MAX_PARAMS + (acc - target - 1);
            a.name  = tbl_name[ei];
            a.value = tbl_value[ei];
            break;
          end
          n = n / cnt;
        end
      end
    end
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: pops the command backlog, holds start until the transfer, then
  // idles for the drawn gap. Everything changes on the falling edge.
  // --------------------------------------------------------------------------
  cmd_item_t   cmd_backlog [$];
  answer_t     due_answers [$];
  int unsigned gap_max = 0;
  int unsigned idle_left = 0;
  logic        took = 1'b0;       // start transfer seen at the last rising edge

  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !took) begin
        // still waiting for busy to drop
      end else if (idle_left != 0) begin
        start <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (cmd_backlog.size() != 0) begin
        cur = cmd_backlog.pop_front();
        start <= 1'b1;
        idle_left <= $urandom_range(0, gap_max);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on each command transfer, checks each result strobe.
  // --------------------------------------------------------------------------
  int unsigned errors = 0;
  int unsigned n_issued = 0;      // commands queued by the stimulus
  int unsigned n_checked = 0;     // results matched against a prediction
  int unsigned n_loads = 0;
  int unsigned n_clears = 0;
  int unsigned n_queries = 0;
  int unsigned n_status [3] = '{0, 0, 0};

  task automatic check_field(input string what, input logic [cpe_pkg::PERM_W-1:0] want,
                             input logic [cpe_pkg::PERM_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (out_valid) begin
        if (due_answers.size() == 0) begin
          $display("%0t: result with no command outstanding (status %0d)",
                   $time, out_status);
          errors++;
        end else begin
          want = due_answers.pop_front();
          check_field("status", want.status, out_status);
          check_field("num_permutations", want.perms, out_num_permutations);
          check_field("param_total", want.npar, out_param_total);
          check_field("entry_name", want.name, out_entry_name);
          check_field("entry_value", want.value, out_entry_value);
          n_status[want.status]++;
          n_checked++;
        end
      end
      if (start && !busy) begin
        due_answers = {due_answers, resolve_cmd(cur)};
        case (cur.req)
          cpe_pkg::REQ_LOAD:  n_loads++;
          cpe_pkg::REQ_CLEAR: n_clears++;
          cpe_pkg::REQ_QUERY: n_queries++;
          default: begin
          end
        endcase
      end
    end
  end

  // Watchdog: any transfer on either channel or the config port resets it.
  int unsigned stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, due_answers.size());
        $display("[cartesian_product_entry_decoder] ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus side. The generator keeps its own view of how far each set is
  // filled so a load never leaves an unwritten slot below a set's count.
  // --------------------------------------------------------------------------
  int unsigned gen_fill [cpe_pkg::NSETS];
  int unsigned gen_sets [cpe_pkg::MAX_DISTS];
  int unsigned gen_dtot;

  task automatic add_cmd(input cmd_item_t c);
    int unsigned si;
    si = c.dsel * cpe_pkg::MAX_SETS + c.ssel;
    if (c.req == cpe_pkg::REQ_LOAD) begin
      if (gen_fill[si] < c.slot + 1) gen_fill[si] = c.slot + 1;
      if (gen_sets[c.dsel] < c.ssel + 1) gen_sets[c.dsel] = c.ssel + 1;
      if (gen_dtot < c.dsel + 1) gen_dtot = c.dsel + 1;
    end else if (c.req == cpe_pkg::REQ_CLEAR) begin
      foreach (gen_fill[i]) gen_fill[i] = 0;
      foreach (gen_sets[i]) gen_sets[i] = 0;
      gen_dtot = 0;
    end
    cmd_backlog = {cmd_backlog, c};
    n_issued++;
  endtask

  function automatic cmd_item_t mk_cmd(cpe_pkg::req_t rq, int d, int s, int k, int nm,
                                       int vl, int pi);
    cmd_item_t c;
    c.req   = rq;
    c.dsel  = cpe_pkg::DIST_W'(d);
    c.ssel  = cpe_pkg::SET_W'(s);
    c.slot  = cpe_pkg::SLOT_W'(k);
    c.name  = cpe_pkg::HANDLE_W'(nm);
    c.value = cpe_pkg::HANDLE_W'(vl);
    c.pidx  = cpe_pkg::PIDX_W'(pi);
    return c;
  endfunction

  function automatic logic [cpe_pkg::HANDLE_W-1:0] rand_handle();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return cpe_pkg::HANDLE_W'($urandom);
    endcase
  endfunction

  // Mostly loads that grow the table in order and queries around the current
  // parameter count; a little noise (gapped loads, wild indexes, nops, clears).
  function automatic cmd_item_t rand_cmd(int unsigned np_hint);
    cmd_item_t   c;
    int unsigned pick;
    int unsigned si;
    c.dsel  = cpe_pkg::DIST_W'($urandom);
    c.ssel  = cpe_pkg::SET_W'($urandom);
    c.slot  = cpe_pkg::SLOT_W'($urandom);
    c.name  = rand_handle();
    c.value = rand_handle();
    c.pidx  = cpe_pkg::PIDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 27) begin
      c.req = cpe_pkg::REQ_LOAD;
      if (pick >= 2) begin
        c.dsel = cpe_pkg::DIST_W'($urandom_range(0, gen_dtot < cpe_pkg::MAX_DISTS ?
                                                 gen_dtot : cpe_pkg::MAX_DISTS - 1));
        c.ssel = cpe_pkg::SET_W'($urandom_range(0, gen_sets[c.dsel] < cpe_pkg::MAX_SETS ?
                                                gen_sets[c.dsel] : cpe_pkg::MAX_SETS - 1));
      end
      si = c.dsel * cpe_pkg::MAX_SETS + c.ssel;
      c.slot = cpe_pkg::SLOT_W'($urandom_range(0, gen_fill[si] < cpe_pkg::MAX_PARAMS ?
                                               gen_fill[si] : cpe_pkg::MAX_PARAMS - 1));
    end else if (pick < 28) begin
      c.req = cpe_pkg::REQ_CLEAR;
    end else if (pick < 31) begin
      c.req = cpe_pkg::REQ_NOP;
    end else begin
      c.req = cpe_pkg::REQ_QUERY;
      if (pick >= 36) c.pidx = cpe_pkg::PIDX_W'($urandom_range(0, np_hint + 1));
    end
    return c;
  endfunction

  // Wait for every queued command to come back and the block to go idle.
  task automatic settle();
    while (n_checked != n_issued) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic cfg_check(input logic idx, input logic [31:0] want,
                           input logic [31:0] mask);
    logic [31:0] got;
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
    if ((got & mask) !== want) begin
      $display("%0t: register %0d readback, expected 0x%0h, got 0x%0h",
               $time, idx, want, got & mask);
      errors++;
    end
  endtask

  // Write both index registers, mirror them in the model, read them back.
  task automatic program_index(input logic [31:0] perm, input logic valid);
    cfg_write(cpe_pkg::CFG_IDX_PERM, perm);
    cfg_perm = perm;
    cfg_write(cpe_pkg::CFG_IDX_VALID, {31'b0, valid});
    cfg_valid = valid;
    cfg_check(cpe_pkg::CFG_IDX_PERM, perm, '1);
    cfg_check(cpe_pkg::CFG_IDX_VALID, {31'b0, valid}, 32'h1);
  endtask

  initial begin
    int unsigned                n_random;
    int unsigned                n_settings;
    int unsigned                np_hint;
    logic [cpe_pkg::PERM_W-1:0] perms;
    logic [31:0]                perm;
    logic                       valid;

    wipe_table();
    foreach (gen_fill[i]) gen_fill[i] = 0;
    foreach (gen_sets[i]) gen_sets[i] = 0;
    gen_dtot = 0;
    n_random = 0;
    n_settings = 1;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // ---- directed part ------------------------------------------------------
    // registers at reset: no index set, so queries report no valid index
    gap_max = 2;
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0));
    add_cmd(mk_cmd(cpe_pkg::REQ_LOAD, 0, 0, 0, 'hFFFF, 'h0000, 'hFF));
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 7, 15, 7, 'hFFFF, 'hFFFF, 0));
    settle();
    program_index(0, 1'b1);
    n_settings++;
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0));     // single entry, found
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 1));     // parameter index == count
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 'hFF));  // largest parameter index
    // distribution 2 loaded with 1 empty: no permutations at all
    add_cmd(mk_cmd(cpe_pkg::REQ_LOAD, 2, 0, 0, 'h0000, 'hFFFF, 0));
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0));
    add_cmd(mk_cmd(cpe_pkg::REQ_LOAD, 1, 0, 0, 'hA5A5, 'h5A5A, 0));
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0));
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 2));
    add_cmd(mk_cmd(cpe_pkg::REQ_NOP, 7, 15, 7, 'hFFFF, 'hFFFF, 'hFF));
    for (int k = 0; k < 4; k++)
      add_cmd(mk_cmd(cpe_pkg::REQ_LOAD, 0, 15, k, 'h1000 + k, 'hE000 + k, 0));
    settle();
    // last set of distribution 0 is the top digit
    program_index(15, 1'b1);
    n_settings++;
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0));
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 5));
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 6));
    settle();
    // permutation number one past the end
    program_index(16, 1'b1);
    n_settings++;
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0));
    add_cmd(mk_cmd(cpe_pkg::REQ_LOAD, 7, 15, 0, 'hFFFF, 'hFFFF, 0));
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0));
    add_cmd(mk_cmd(cpe_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    add_cmd(mk_cmd(cpe_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0));

    // ---- random part: one register setting per burst -----------------------
    while (n_random < RANDOM_CMDS) begin
      settle();
      perms = perm_total();
      case ($urandom_range(0, 9))
        0:       perm = '1;
        1:       perm = $urandom;
        2:       perm = perms[cpe_pkg::PERM_W-1] ? $urandom : perms[31:0];
        3:       perm = '0;
        default: perm = (perms == 0) ? $urandom : $urandom_range(0, 32'(perms - 1));
      endcase
      valid = ($urandom_range(0, 9) != 0);
      program_index(perm, valid);
      n_settings++;
      np_hint = index_in_range() ? params_picked() : cpe_pkg::MAX_PARAMS;

      case ($urandom_range(0, 3))
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 18;
      endcase

      if ($urandom_range(0, 7) == 0)
        add_cmd(mk_cmd(cpe_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom));
      repeat ($urandom_range(10, 40)) begin
        add_cmd(rand_cmd(np_hint));
        n_random++;
      end
    end

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d commands under %0d register settings: %0d loads, %0d clears, %0d queries",
             n_issued, n_settings, n_loads, n_clears, n_queries);
    $display("results: %0d ok, %0d without valid index, %0d parameter out of range",
             n_status[cpe_pkg::ST_OK], n_status[cpe_pkg::ST_NO_INDEX],
             n_status[cpe_pkg::ST_PARAM_RANGE]);
    if (errors == 0) begin
      $display("[cartesian_product_entry_decoder] OK");
    end else begin
      $display("[cartesian_product_entry_decoder] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cpe_pkg.sv
hw/rtl/cpe_ctrl.sv
hw/rtl/cpe_dp.sv
hw/rtl/cartesian_product_entry_decoder.sv
tb/tb_cartesian_product_entry_decoder.sv
